// File: sv/priority_channel_merge_defines.svh
// ----------------------------------------------------------------------------
// priority_channel_merge_defines
// Assertion macros used by the checker file of the channel merge block.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_CHANNEL_MERGE_DEFINES_SVH
`define PRIORITY_CHANNEL_MERGE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define PCM_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define PCM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Types and constants shared by the channel merge controller and datapath.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int ACTION_W = 2;
    localparam int LEVEL_W  = 8;
    localparam int CHAN_W   = 9;
    localparam int VALUE_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    // one level's entry for one channel
    typedef struct packed {
        logic               mask;
        logic [VALUE_W-1:0] value;
    } t_lane;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // beat taken this cycle
        logic clear;    // clearing pass: zero one row
        logic resp;     // build the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // last row is being cleared
    } t_dp_status;

endpackage

// File: sv/pcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_ctrl
// Sequencer: clearing pass after reset, then accept / respond per beat.
// ----------------------------------------------------------------------------
module pcm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  pcm_pkg::t_dp_status i_status,
    output pcm_pkg::t_dp_cmd    o_cmd,
    output logic                busy,
    output logic                o_strobe
);
    import pcm_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;
    logic   r_strobe, n_strobe;

    always_comb begin
        o_cmd.clear  = (r_state == ST_CLEAR);
        o_cmd.accept = (r_state == ST_IDLE) && start;
        o_cmd.resp   = (r_state == ST_RESP);
    end

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RESP;
                    n_busy  = 1'b1;
                end
            end
            ST_RESP: begin
                n_state  = ST_IDLE;
                n_busy   = 1'b0;
                n_strobe = 1'b1;
            end
            default: begin
                n_state = ST_CLEAR;
                n_busy  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

// File: sv/pcm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dpath
// Per-channel row memory of level lanes, priority select, changed flag.
// ----------------------------------------------------------------------------
module pcm_dpath #(
    parameter int LEVELS   = 4,
    parameter int CHANNELS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcm_pkg::t_dp_cmd              i_cmd,
    output pcm_pkg::t_dp_status           o_status,
    input  logic [pcm_pkg::ACTION_W-1:0]  i_action,
    input  logic [pcm_pkg::LEVEL_W-1:0]   i_level,
    input  logic [pcm_pkg::CHAN_W-1:0]    i_channel,
    input  logic [pcm_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_mask_bit,
    output logic [pcm_pkg::VALUE_W-1:0]   o_merged_value,
    output logic                          o_found,
    output logic                          o_changed
);
    import pcm_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LV_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int EXT_W = (CH_W > CHAN_W) ? CH_W : CHAN_W;

    t_lane [LEVELS-1:0] mem [CHANNELS];

    logic [CH_W-1:0]    r_clr_idx;
    t_lane [LEVELS-1:0] r_row;
    t_action            r_action;
    logic               r_ch_ok;
    logic               r_changed;
    logic [VALUE_W-1:0] r_merged;
    logic               r_found;
    logic               r_out_changed;

    t_action            act;
    logic               ch_ok;
    logic               lv_ok;
    logic               wr_en;
    logic [EXT_W-1:0]   ch_ext;
    logic [CH_W-1:0]    ch_idx;
    logic [LV_W-1:0]    lv_idx;
    logic [VALUE_W-1:0] n_merged;
    logic               n_found;

    assign act    = t_action'(i_action);
    assign ch_ok  = int'(i_channel) < CHANNELS;
    assign lv_ok  = int'(i_level) < LEVELS;
    assign ch_ext = EXT_W'(i_channel);
    assign ch_idx = ch_ext[CH_W-1:0];
    assign lv_idx = i_level[LV_W-1:0];
    assign wr_en  = i_cmd.accept && (act == ACT_WRITE) && ch_ok && lv_ok;

    assign o_status.clear_last = (r_clr_idx == CH_W'(CHANNELS - 1));

    // row memory: one row write or one lane write per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr_idx] <= '0;
        end else if (wr_en) begin
            mem[ch_idx][lv_idx] <= '{mask: i_mask_bit, value: i_value};
        end
        if (i_cmd.accept) begin
            r_row <= mem[ch_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_changed <= 1'b0;
        end else if (i_cmd.accept) begin
            unique case (act)
                ACT_WRITE:  if (ch_ok && lv_ok) r_changed <= 1'b1;
                ACT_FINISH: r_changed <= 1'b0;
                default:    r_changed <= r_changed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= act;
            r_ch_ok  <= ch_ok;
        end
    end

    // lowest-numbered claiming level wins
    always_comb begin
        n_merged = '0;
        n_found  = 1'b0;
        if (r_action == ACT_READ && r_ch_ok) begin
            for (int l = LEVELS - 1; l >= 0; l--) begin
                if (r_row[l].mask) begin
                    n_merged = r_row[l].value;
                    n_found  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_merged      <= n_merged;
            r_found       <= n_found;
            r_out_changed <= r_changed;
        end
    end

    assign o_merged_value = r_merged;
    assign o_found        = r_found;
    assign o_changed      = r_out_changed;

endmodule

// File: sv/priority_channel_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_channel_merge
// Prioritized merge of channel values over LEVELS masked priority levels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_action/i_level/i_channel/i_value/i_mask_bit and
//   raise start; the beat is taken at the clock edge where start is high and
//   busy is low. Actions: write one level's value and mask bit for a channel,
//   read the merged value of a channel, finish (clears the changed flag).
//   Result channel: o_strobe is high for exactly one cycle with
//   o_merged_value, o_found and o_changed; the receiver cannot stall it, so
//   it must take the beat in that cycle.
// Sequence per beat:
//   At the accepting edge the row of the channel memory (all levels of a
//   channel in one word) and the action are registered. In the respond
//   state that follows, the priority select works on that row, and at its
//   end the result and the strobe are registered and busy falls. Busy is
//   high through the respond state, so a new beat is not taken before the
//   last beat's result is registered.
// Reset:
//   i_rst_n is synchronous, active low. After it a clearing pass zeroes the
//   channel memory one row a cycle, every row in turn, with busy held high.
//   The changed flag resets to zero.
// ----------------------------------------------------------------------------
module priority_channel_merge #(
    parameter int LEVELS   = 4,
    parameter int CHANNELS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pcm_pkg::ACTION_W-1:0]  i_action,
    input  logic [pcm_pkg::LEVEL_W-1:0]   i_level,
    input  logic [pcm_pkg::CHAN_W-1:0]    i_channel,
    input  logic [pcm_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_mask_bit,
    output logic                          o_strobe,
    output logic [pcm_pkg::VALUE_W-1:0]   o_merged_value,
    output logic                          o_found,
    output logic                          o_changed
);
    import pcm_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: clearing pass, accept, respond
    pcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // row memory, priority select and changed flag
    pcm_dpath #(
        .LEVELS   (LEVELS),
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_level        (i_level),
        .i_channel      (i_channel),
        .i_value        (i_value),
        .i_mask_bit     (i_mask_bit),
        .o_merged_value (o_merged_value),
        .o_found        (o_found),
        .o_changed      (o_changed)
    );

endmodule

// File: sv/pcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_checker
// Port-level checks of the channel merge block, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_channel_merge_defines.svh"

module pcm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [pcm_pkg::ACTION_W-1:0]  i_action,
    input logic                          o_strobe,
    input logic [pcm_pkg::VALUE_W-1:0]   o_merged_value,
    input logic                          o_found,
    input logic                          o_changed
);
    import pcm_pkg::*;

    // every taken beat is answered by a result strobe
    `PCM_CHECK(a_resp_follows, start && !busy, ##2 o_strobe, "missing result beat")
    // no result without a matching taken beat before it
    `PCM_CHECK(a_no_stray, o_strobe, $past(start && !busy, 2), "result without beat")
    // a beat in flight holds busy
    `PCM_CHECK_NEXT(a_busy_flight, start && !busy, busy, "busy low while in flight")
    // only a read can report a claimed value
    `PCM_CHECK(a_nonread_empty, o_strobe && ($past(i_action, 2) != ACT_READ),
        !o_found && (o_merged_value == '0), "non-read result carries data")
    // finish leaves the changed flag low
    `PCM_CHECK(a_finish_clears, o_strobe && ($past(i_action, 2) == ACT_FINISH),
        !o_changed, "changed flag set after finish")

endmodule

bind priority_channel_merge pcm_checker u_pcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_action       (i_action),
    .o_strobe       (o_strobe),
    .o_merged_value (o_merged_value),
    .o_found        (o_found),
    .o_changed      (o_changed)
);

// File: verif/priority_channel_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_channel_merge_tb
// Self-checking bench for the prioritized channel merge. Commands (write,
// read, finish and the unused code) are driven over the start/busy handshake.
// A bench-side copy of the level stores and the changed flag predicts every
// result, and each strobed result is compared field by field in arrival
// order. Directed cases cover the field extremes, priority ordering, the
// clear-mask case, out-of-range levels and the unused action code. Random
// frames follow: a run of channel writes at one level, read back, with
// noise beats mixed in.
// ----------------------------------------------------------------------------
module priority_channel_merge_tb;

    import pcm_pkg::*;

    localparam int LEVELS         = 4;
    localparam int CHANNELS       = 512;
    localparam int RANDOM_BEATS   = 1680;
    localparam int WATCHDOG_LIMIT = 4000;   // must outlast the clearing pass after reset
    localparam int DRAIN_CYCLES   = 6;
    localparam int MAX_REPORTS    = 40;

    // action code 3 has no enum member; the block must treat it as a no-op
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] merged_value;
        logic               found;
        logic               changed;
    } t_merge_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    logic [ACTION_W-1:0] i_action   = ACT_FINISH;
    logic [LEVEL_W-1:0]  i_level    = '0;
    logic [CHAN_W-1:0]   i_channel  = '0;
    logic [VALUE_W-1:0]  i_value    = '0;
    logic                i_mask_bit = 1'b0;
    logic                o_strobe;
    logic [VALUE_W-1:0]  o_merged_value;
    logic                o_found;
    logic                o_changed;

    // bench copy of the block state
    logic [VALUE_W-1:0]  level_value [LEVELS][CHANNELS];
    logic                level_claim [LEVELS][CHANNELS];
    logic                render_changed;

    t_merge_result       merges_due[$];
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    bit                  gaps_enabled   = 1'b1;

    always #1 i_clk = ~i_clk;

    priority_channel_merge #(
        .LEVELS   (LEVELS),
        .CHANNELS (CHANNELS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_level        (i_level),
        .i_channel      (i_channel),
        .i_value        (i_value),
        .i_mask_bit     (i_mask_bit),
        .o_strobe       (o_strobe),
        .o_merged_value (o_merged_value),
        .o_found        (o_found),
        .o_changed      (o_changed)
    );

    function automatic void clear_merge_state();
        for (int l = 0; l < LEVELS; l++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                level_value[l][c] = '0;
                level_claim[l][c] = 1'b0;
            end
        end
        render_changed = 1'b0;
    endfunction

    // Applies one command to the bench state and returns the result it gives.
    function automatic t_merge_result predict_merge(
        input logic [ACTION_W-1:0] act,
        input logic [LEVEL_W-1:0]  lvl,
        input logic [CHAN_W-1:0]   ch,
        input logic [VALUE_W-1:0]  val,
        input logic                mbit
    );
        t_merge_result res;
        res = '0;
        if (act == ACT_WRITE) begin
            // either index out of range drops the write entirely
            if (int'(lvl) < LEVELS && int'(ch) < CHANNELS) begin
                level_value[lvl][ch] = val;
                level_claim[lvl][ch] = mbit;
                render_changed       = 1'b1;
            end
        end else if (act == ACT_READ) begin
            if (int'(ch) < CHANNELS) begin
                for (int l = LEVELS - 1; l >= 0; l--) begin
                    // walk down from the top level so the lowest claiming level wins
                    if (level_claim[l][ch]) begin
                        res.merged_value = level_value[l][ch];
                        res.found        = 1'b1;
                    end
                end
            end
        end else if (act == ACT_FINISH) begin
            render_changed = 1'b0;
        end
        res.changed = render_changed;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Drives one command beat and returns at the edge that takes it.
    task automatic send_beat(
        input logic [ACTION_W-1:0] act,
        input logic [LEVEL_W-1:0]  lvl,
        input logic [CHAN_W-1:0]   ch,
        input logic [VALUE_W-1:0]  val,
        input logic                mbit
    );
        if (gaps_enabled && $urandom_range(0, 99) < 38) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_level    <= lvl;
        i_channel  <= ch;
        i_value    <= val;
        i_mask_bit <= mbit;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Checks strobed results, then predicts the beat taken at this edge.
    // Everything here sees pre-edge values.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                moved = 1'b1;
                if (merges_due.size() == 0) begin
                    report_mismatch("unpredicted result beat", 1, 0);
                end else begin
                    t_merge_result want;
                    want = merges_due.pop_front();
                    if (o_merged_value !== want.merged_value)
                        report_mismatch("merged_value", int'(o_merged_value),
                                        int'(want.merged_value));
                    if (o_found !== want.found)
                        report_mismatch("found", int'(o_found), int'(want.found));
                    if (o_changed !== want.changed)
                        report_mismatch("changed", int'(o_changed), int'(want.changed));
                end
            end
            if (start && busy === 1'b0) begin
                moved = 1'b1;
                merges_due.push_back(predict_merge(i_action, i_level, i_channel,
                                                   i_value, i_mask_bit));
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Unwritten stores read back as unclaimed.
    task automatic test_reset_state();
        send_beat(ACT_READ, 8'd0, 9'd0, 8'hFF, 1'b1);
        send_beat(ACT_READ, 8'd0, 9'd511, 8'h00, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_beat(ACT_WRITE, 8'd0, 9'd0, 8'hFF, 1'b1);
        send_beat(ACT_READ, 8'd0, 9'd0, 8'h00, 1'b0);
        send_beat(ACT_WRITE, 8'd3, 9'd511, 8'h00, 1'b1);
        send_beat(ACT_READ, 8'd255, 9'd511, 8'hFF, 1'b1);
    endtask

    // Lower level wins; a write with mask clear stores but does not claim.
    task automatic test_priority_order();
        send_beat(ACT_WRITE, 8'd3, 9'd7, 8'h33, 1'b1);
        send_beat(ACT_READ, 8'd0, 9'd7, 8'h00, 1'b0);
        send_beat(ACT_WRITE, 8'd1, 9'd7, 8'h11, 1'b1);
        send_beat(ACT_READ, 8'd0, 9'd7, 8'h00, 1'b0);
        send_beat(ACT_WRITE, 8'd0, 9'd7, 8'h5A, 1'b0);
        send_beat(ACT_READ, 8'd0, 9'd7, 8'h00, 1'b0);
        send_beat(ACT_WRITE, 8'd1, 9'd7, 8'hA5, 1'b0);
        send_beat(ACT_READ, 8'd0, 9'd7, 8'h00, 1'b0);
    endtask

    // Out-of-range level writes are dropped and must not raise changed.
    task automatic test_level_out_of_range();
        send_beat(ACT_FINISH, 8'd0, 9'd0, 8'h00, 1'b0);
        send_beat(ACT_WRITE, 8'd4, 9'd9, 8'hC3, 1'b1);
        send_beat(ACT_WRITE, 8'd255, 9'd9, 8'h3C, 1'b1);
        send_beat(ACT_READ, 8'd0, 9'd9, 8'h00, 1'b0);
    endtask

    // Unused action code is a no-op reporting the current flag.
    task automatic test_unused_action();
        send_beat(ACT_WRITE, 8'd2, 9'd100, 8'h81, 1'b1);
        send_beat(ACT_UNUSED, 8'd2, 9'd100, 8'h7E, 1'b1);
        send_beat(ACT_READ, 8'd2, 9'd100, 8'h00, 1'b0);
        send_beat(ACT_FINISH, 8'd2, 9'd100, 8'h00, 1'b1);
        send_beat(ACT_UNUSED, 8'd255, 9'd511, 8'hFF, 1'b0);
    endtask

    // Mostly frames: a run of writes at one level, read back, often finished.
    // The rest is single beats with fully random fields.
    task automatic test_random_traffic();
        int                 sent;
        int                 frame_len;
        logic [CHAN_W-1:0]  base_ch;
        logic [LEVEL_W-1:0] lvl;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            // one long stretch runs back to back
            gaps_enabled = !(sent >= 500 && sent < 850);
            if ($urandom_range(0, 99) < 65) begin
                frame_len = $urandom_range(1, 8);
                // half the frames land on a small hot set so levels stack up
                base_ch = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 15))
                                               : CHAN_W'($urandom_range(0, CHANNELS - 1));
                lvl = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(LEVELS, 255))
                                                  : LEVEL_W'($urandom_range(0, LEVELS - 1));
                for (int k = 0; k < frame_len; k++)
                    send_beat(ACT_WRITE, lvl, base_ch + CHAN_W'(k),
                              VALUE_W'($urandom_range(0, 255)),
                              $urandom_range(0, 99) < 75);
                for (int k = 0; k < frame_len; k++)
                    send_beat(ACT_READ, LEVEL_W'($urandom_range(0, 255)),
                              base_ch + CHAN_W'(k), VALUE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                sent += 2 * frame_len;
                if ($urandom_range(0, 1)) begin
                    send_beat(ACT_FINISH, '0, '0, '0, 1'b0);
                    sent++;
                end
            end else begin
                send_beat(ACTION_W'($urandom_range(0, 3)), LEVEL_W'($urandom_range(0, 255)),
                          CHAN_W'($urandom_range(0, CHANNELS - 1)),
                          VALUE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        clear_merge_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_field_extremes();
        test_priority_order();
        test_level_out_of_range();
        test_unused_action();
        test_random_traffic();

        start <= 1'b0;
        while (merges_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: priority_channel_merge.f
+incdir+sv
sv/pcm_pkg.sv
sv/pcm_ctrl.sv
sv/pcm_dpath.sv
sv/priority_channel_merge.sv
sv/pcm_checker.sv
verif/priority_channel_merge_tb.sv
